// ----- src/motor_voltage_pi_regulator_macros.svh -----
// ----------------------------------------------------------------------------
// Motor voltage PI regulator assertion macros
// Concurrent checks on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef MOTOR_VOLTAGE_PI_REGULATOR_MACROS_SVH
`define MOTOR_VOLTAGE_PI_REGULATOR_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define MVPI_ASSERT_IMPL(label, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
        else $error("%m: implication check failed");

// next-cycle implication
`define MVPI_ASSERT_NEXT(label, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
        else $error("%m: next-cycle check failed");

`else

`define MVPI_ASSERT_IMPL(label, lhs, rhs)
`define MVPI_ASSERT_NEXT(label, lhs, rhs)

`endif

`endif

// ----- src/mvpi_pkg.sv -----
// ----------------------------------------------------------------------------
// mvpi_pkg
// Shared types, constants and the setpoint level table of the regulator.
// ----------------------------------------------------------------------------
`default_nettype none

package mvpi_pkg;

    localparam int ADDR_W        = 5;
    localparam int DATA_W        = 32;
    localparam int TABLE_ENTRIES = 22;
    localparam int STEP          = 5;
    // sum of up to eight 8-bit samples
    localparam int SUM_W         = 11;
    // |err| * ERR_RECIP >> 16 == |err| / 20 for |err| < 256
    localparam int ERR_RECIP     = 3277;
    // t * DIV5_RECIP >> 10 == t / 5 for t < 128
    localparam int DIV5_RECIP    = 205;

    localparam logic [6:0]  RST_MAX_SETPOINT  = 7'd110;
    localparam logic [7:0]  RST_REPEAT_DELAY  = 8'd20;
    localparam logic [14:0] RST_INT_LIMIT     = 15'd240;
    localparam logic [7:0]  RST_BATT_FULL     = 8'd252;
    localparam logic [7:0]  RST_BATT_MID      = 8'd248;
    localparam logic [7:0]  RST_BATT_LOW_ENT  = 8'd240;
    localparam logic [7:0]  RST_BATT_LOW_EXIT = 8'd245;

    localparam logic [1:0] LEVEL_FULL   = 2'd0;
    localparam logic [1:0] LEVEL_MEDIUM = 2'd1;
    localparam logic [1:0] LEVEL_LOW_OK = 2'd2;
    localparam logic [1:0] LEVEL_CUTOFF = 2'd3;

    typedef enum logic [2:0] {
        REG_MAX_SETPOINT,
        REG_REPEAT_DELAY,
        REG_INTEGRAL_LIMIT,
        REG_BATTERY_FULL,
        REG_BATTERY_MID,
        REG_BATTERY_LOW_ENTER,
        REG_BATTERY_LOW_EXIT
    } reg_index_t;

    typedef struct packed {
        logic [6:0]  max_setpoint;
        logic [7:0]  repeat_delay;
        logic [14:0] integral_limit;
        logic [7:0]  battery_full_level;
        logic [7:0]  battery_mid_level;
        logic [7:0]  battery_low_enter;
        logic [7:0]  battery_low_exit;
    } cfg_t;

    typedef struct packed {
        logic [7:0] motor_sample;
        logic [7:0] battery_sample;
        logic       battery_update;
        logic       key_down;
        logic       key_up;
        logic       drive_enable;
    } tick_t;

    typedef struct packed {
        logic [7:0] duty;
        logic [6:0] setpoint;
        logic [1:0] battery_level;
        logic [7:0] motor_average;
    } result_t;

    // word handed from the front to the back
    typedef struct packed {
        logic [SUM_W-1:0] sample_sum;
        logic [6:0]       setpoint;
        logic [1:0]       battery_level;
        logic             battery_low;
        logic             drive_enable;
    } task_t;

    function automatic logic [7:0] level_table(input logic [4:0] idx);
        logic [7:0] lvl;
        case (idx)
            5'd0:    lvl = 8'd255;
            5'd1:    lvl = 8'd255;
            5'd2:    lvl = 8'd255;
            5'd3:    lvl = 8'd187;
            5'd4:    lvl = 8'd178;
            5'd5:    lvl = 8'd170;
            5'd6:    lvl = 8'd165;
            5'd7:    lvl = 8'd158;
            5'd8:    lvl = 8'd140;
            5'd9:    lvl = 8'd130;
            5'd10:   lvl = 8'd124;
            5'd11:   lvl = 8'd112;
            5'd12:   lvl = 8'd105;
            5'd13:   lvl = 8'd93;
            5'd14:   lvl = 8'd85;
            5'd15:   lvl = 8'd71;
            5'd16:   lvl = 8'd62;
            5'd17:   lvl = 8'd51;
            5'd18:   lvl = 8'd40;
            5'd19:   lvl = 8'd28;
            5'd20:   lvl = 8'd7;
            default: lvl = 8'd0;
        endcase
        return lvl;
    endfunction

endpackage

`default_nettype wire

// ----- src/motor_voltage_pi_regulator.sv -----
// ----------------------------------------------------------------------------
// Motor voltage PI regulator: one tick word in, one result word out.
// Path: task queue, back stage 1 and 2 registers, then the result queue's head.
// Throughput: one word per cycle unless full; the integral holds on a zero setpoint.
// Reset: async low; ring at 255, setpoint, integral, keys and battery cleared.
// ----------------------------------------------------------------------------
`default_nettype none

`include "motor_voltage_pi_regulator_macros.svh"

module motor_voltage_pi_regulator #(
    parameter int FILTER_DEPTH = 3,
    parameter int QUEUE_DEPTH  = 2
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [mvpi_pkg::ADDR_W-1:0] paddr,
    input  wire logic [mvpi_pkg::DATA_W-1:0] pwdata,
    output logic      [mvpi_pkg::DATA_W-1:0] prdata,
    output logic                             pready,
    input  wire logic                        push,
    input  mvpi_pkg::tick_t                  tick,
    output logic                             full,
    input  wire logic                        pop,
    output mvpi_pkg::result_t                result,
    output logic                             empty
);
    import mvpi_pkg::*;

    cfg_t    cfg;
    task_t   front_word;
    task_t   mid_word;
    result_t back_word;
    logic    accept;
    logic    mid_empty;
    logic    mid_pop;
    logic    out_full;
    logic    out_push;

    assign accept = push && !full;

    mvpi_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    mvpi_front #(
        .FILTER_DEPTH (FILTER_DEPTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .accept    (accept),
        .tick      (tick),
        .task_word (front_word)
    );

    mvpi_fifo #(
        .word_t (task_t),
        .DEPTH  (QUEUE_DEPTH)
    ) u_mid_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (front_word),
        .full  (full),
        .pop   (mid_pop),
        .rdata (mid_word),
        .empty (mid_empty)
    );

    mvpi_back #(
        .FILTER_DEPTH (FILTER_DEPTH)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .integral_limit (cfg.integral_limit),
        .task_word      (mid_word),
        .task_empty     (mid_empty),
        .task_pop       (mid_pop),
        .out_full       (out_full),
        .out_push       (out_push),
        .out_word       (back_word)
    );

    mvpi_fifo #(
        .word_t (result_t),
        .DEPTH  (QUEUE_DEPTH)
    ) u_out_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (out_push),
        .wdata (back_word),
        .full  (out_full),
        .pop   (pop),
        .rdata (result),
        .empty (empty)
    );

    `MVPI_ASSERT_IMPL(a_cutoff_no_drive, !empty && (result.battery_level == LEVEL_CUTOFF), result.duty == 8'd0)
    `MVPI_ASSERT_IMPL(a_zero_setpoint_idle, !empty && (result.setpoint == 7'd0), result.duty == 8'd0)
    `MVPI_ASSERT_NEXT(a_accept_queued, accept, !mid_empty)

endmodule

`default_nettype wire

// ----- src/mvpi_cfg.sv -----
// ----------------------------------------------------------------------------
// mvpi_cfg
// APB register bank holding the regulator configuration.
// ----------------------------------------------------------------------------
`default_nettype none

module mvpi_cfg (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [mvpi_pkg::ADDR_W-1:0] paddr,
    input  wire logic [mvpi_pkg::DATA_W-1:0] pwdata,
    output logic      [mvpi_pkg::DATA_W-1:0] prdata,
    output logic                            pready,
    output mvpi_pkg::cfg_t                  cfg
);
    import mvpi_pkg::*;

    cfg_t       cfg_reg;
    reg_index_t idx;
    logic       wr_en;

    assign idx    = reg_index_t'(paddr[ADDR_W-1:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.max_setpoint       <= RST_MAX_SETPOINT;
            cfg_reg.repeat_delay       <= RST_REPEAT_DELAY;
            cfg_reg.integral_limit     <= RST_INT_LIMIT;
            cfg_reg.battery_full_level <= RST_BATT_FULL;
            cfg_reg.battery_mid_level  <= RST_BATT_MID;
            cfg_reg.battery_low_enter  <= RST_BATT_LOW_ENT;
            cfg_reg.battery_low_exit   <= RST_BATT_LOW_EXIT;
        end
        else if (wr_en)
        begin
            unique case (idx)
                REG_MAX_SETPOINT:      cfg_reg.max_setpoint       <= pwdata[6:0];
                REG_REPEAT_DELAY:      cfg_reg.repeat_delay       <= pwdata[7:0];
                REG_INTEGRAL_LIMIT:    cfg_reg.integral_limit     <= pwdata[14:0];
                REG_BATTERY_FULL:      cfg_reg.battery_full_level <= pwdata[7:0];
                REG_BATTERY_MID:       cfg_reg.battery_mid_level  <= pwdata[7:0];
                REG_BATTERY_LOW_ENTER: cfg_reg.battery_low_enter  <= pwdata[7:0];
                REG_BATTERY_LOW_EXIT:  cfg_reg.battery_low_exit   <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_MAX_SETPOINT:      prdata = DATA_W'(cfg_reg.max_setpoint);
            REG_REPEAT_DELAY:      prdata = DATA_W'(cfg_reg.repeat_delay);
            REG_INTEGRAL_LIMIT:    prdata = DATA_W'(cfg_reg.integral_limit);
            REG_BATTERY_FULL:      prdata = DATA_W'(cfg_reg.battery_full_level);
            REG_BATTERY_MID:       prdata = DATA_W'(cfg_reg.battery_mid_level);
            REG_BATTERY_LOW_ENTER: prdata = DATA_W'(cfg_reg.battery_low_enter);
            REG_BATTERY_LOW_EXIT:  prdata = DATA_W'(cfg_reg.battery_low_exit);
            default:               prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

// ----- src/mvpi_fifo.sv -----
// ----------------------------------------------------------------------------
// mvpi_fifo
// Small synchronous queue of words; depth at least two.
// ----------------------------------------------------------------------------
`default_nettype none

module mvpi_fifo #(
    parameter type word_t = logic,
    parameter int  DEPTH  = 2
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  push,
    input  word_t      wdata,
    output logic       full,
    input  wire logic  pop,
    output word_t      rdata,
    output logic       empty
);
    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    word_t           mem [DEPTH];
    logic [AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg, count_next;
    logic            do_push, do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= wdata;
    end

endmodule

`default_nettype wire

// ----- src/mvpi_front.sv -----
// ----------------------------------------------------------------------------
// mvpi_front
// Takes one tick word a cycle while accept is high: battery state, key handling and the sample
// ring; hands the sum and the classified state on to the back.
// ----------------------------------------------------------------------------
`default_nettype none

module mvpi_front #(
    parameter int FILTER_DEPTH = 3
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  mvpi_pkg::cfg_t cfg,
    input  wire logic     accept,
    input  mvpi_pkg::tick_t tick,
    output mvpi_pkg::task_t task_word
);
    import mvpi_pkg::*;

    localparam int PW = (FILTER_DEPTH > 1) ? $clog2(FILTER_DEPTH) : 1;

    typedef enum logic [1:0] {DIR_NONE, DIR_DOWN, DIR_UP} dir_t;

    logic [7:0]       ring_reg  [FILTER_DEPTH];
    logic [7:0]       ring_next [FILTER_DEPTH];
    logic [PW-1:0]    pos_reg, pos_next;
    logic [6:0]       target_reg, target_next;
    logic             latched_reg, latched_next;
    dir_t             dir_reg, dir_next;
    logic [7:0]       hold_reg, hold_next;
    logic             low_reg, low_next;
    logic [1:0]       level_reg, level_next;
    logic [SUM_W-1:0] sum;

    function automatic logic [6:0] step_dn(input logic [6:0] t);
        return (t >= 7'(STEP)) ? t - 7'(STEP) : 7'd0;
    endfunction

    function automatic logic [6:0] step_up(input logic [6:0] t, input logic [6:0] m);
        logic [7:0] s;
        s = {1'b0, t} + 8'(STEP);
        return (s > {1'b0, m}) ? m : s[6:0];
    endfunction

    // battery classification with hysteresis on the low state
    always_comb
    begin
        low_next   = low_reg;
        level_next = level_reg;
        if (tick.battery_update)
        begin
            if (tick.battery_sample > cfg.battery_full_level)
            begin
                level_next = LEVEL_FULL;
                low_next   = 1'b0;
            end
            else if (tick.battery_sample > cfg.battery_mid_level)
            begin
                level_next = LEVEL_MEDIUM;
                low_next   = 1'b0;
            end
            else if ((tick.battery_sample > cfg.battery_low_enter && !low_reg) ||
                     (tick.battery_sample > cfg.battery_low_exit && low_reg))
            begin
                level_next = LEVEL_LOW_OK;
                low_next   = 1'b0;
            end
            else
            begin
                level_next = LEVEL_CUTOFF;
                low_next   = 1'b1;
            end
        end
    end

    // sample ring and its sum
    always_comb
    begin
        sum = '0;
        for (int i = 0; i < FILTER_DEPTH; i++)
        begin
            ring_next[i] = (pos_reg == PW'(i)) ? tick.motor_sample : ring_reg[i];
            sum = sum + SUM_W'(ring_next[i]);
        end
        pos_next = (pos_reg == PW'(FILTER_DEPTH - 1)) ? '0 : pos_reg + 1'b1;
    end

    // keys: first press steps at once, a held key repeats after the delay
    always_comb
    begin
        target_next  = target_reg;
        latched_next = latched_reg;
        dir_next     = dir_reg;
        hold_next    = hold_reg;
        if (tick.key_down && target_next != 7'd0 && !latched_next)
        begin
            target_next  = step_dn(target_next);
            latched_next = 1'b1;
            dir_next     = DIR_DOWN;
        end
        else if (tick.key_up && target_next < cfg.max_setpoint && !latched_next)
        begin
            target_next  = step_up(target_next, cfg.max_setpoint);
            latched_next = 1'b1;
            dir_next     = DIR_UP;
        end
        if (!tick.key_down && !tick.key_up)
        begin
            latched_next = 1'b0;
            hold_next    = '0;
            dir_next     = DIR_NONE;
        end
        if (dir_next != DIR_NONE)
        begin
            hold_next = hold_next + 8'd1;
            if (hold_next > cfg.repeat_delay)
            begin
                hold_next = '0;
                if (dir_next == DIR_DOWN)
                begin
                    if (target_next != 7'd0)
                        target_next = step_dn(target_next);
                end
                else if (target_next < cfg.max_setpoint)
                begin
                    target_next = step_up(target_next, cfg.max_setpoint);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < FILTER_DEPTH; i++)
                ring_reg[i] <= 8'hFF;
            pos_reg     <= '0;
            target_reg  <= '0;
            latched_reg <= 1'b0;
            dir_reg     <= DIR_NONE;
            hold_reg    <= '0;
            low_reg     <= 1'b0;
            level_reg   <= LEVEL_FULL;
        end
        else if (accept)
        begin
            for (int i = 0; i < FILTER_DEPTH; i++)
                ring_reg[i] <= ring_next[i];
            pos_reg     <= pos_next;
            target_reg  <= target_next;
            latched_reg <= latched_next;
            dir_reg     <= dir_next;
            hold_reg    <= hold_next;
            low_reg     <= low_next;
            level_reg   <= level_next;
        end
    end

    assign task_word.sample_sum    = sum;
    assign task_word.setpoint      = target_next;
    assign task_word.battery_level = level_next;
    assign task_word.battery_low   = low_next;
    assign task_word.drive_enable  = tick.drive_enable;

endmodule

`default_nettype wire

// ----- src/mvpi_back.sv -----
// ----------------------------------------------------------------------------
// mvpi_back
// Three-stage PI datapath: mean and table index, error and error/20,
// integral update and duty. The whole pipe holds while the result queue is full.
// ----------------------------------------------------------------------------
`default_nettype none

module mvpi_back #(
    parameter int FILTER_DEPTH = 3
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic [14:0] integral_limit,
    input  mvpi_pkg::task_t  task_word,
    input  wire logic        task_empty,
    output logic             task_pop,
    input  wire logic        out_full,
    output logic             out_push,
    output mvpi_pkg::result_t out_word
);
    import mvpi_pkg::*;

    localparam int AVG_SHIFT = 20;
    localparam int AVG_MUL   = (2**AVG_SHIFT + FILTER_DEPTH - 1) / FILTER_DEPTH;
    localparam int PROD_W    = SUM_W + AVG_SHIFT + 1;
    localparam logic signed [16:0] INT_FLOOR = -17'sd32768;

    logic adv;

    // stage 1
    logic [PROD_W-1:0] avg_prod;
    logic [14:0]       div5_prod;
    logic [4:0]        idx;
    logic              s1_valid_reg;
    logic [7:0]        s1_avg_reg;
    logic [4:0]        s1_idx_reg;
    logic [6:0]        s1_setpoint_reg;
    logic [1:0]        s1_level_reg;
    logic              s1_gate_reg;

    // stage 2
    logic [7:0]        tbl;
    logic signed [8:0] err;
    logic [8:0]        mag9;
    logic [19:0]       q_prod;
    logic [3:0]        q_mag;
    logic signed [4:0] q;
    logic              s2_valid_reg;
    logic signed [8:0] s2_err_reg;
    logic signed [4:0] s2_q_reg;
    logic [7:0]        s2_avg_reg;
    logic [6:0]        s2_setpoint_reg;
    logic [1:0]        s2_level_reg;
    logic              s2_gate_reg;

    // stage 3
    logic signed [15:0] integ_reg, integ_next;
    logic signed [16:0] isum;
    logic signed [16:0] lim;
    logic signed [18:0] p;
    logic [7:0]         duty;
    logic               active;

    assign adv      = !out_full;
    assign task_pop = adv && !task_empty;

    // sum / FILTER_DEPTH and setpoint / 5 by reciprocal multiplication
    assign avg_prod  = PROD_W'(task_word.sample_sum) * PROD_W'(AVG_MUL);
    assign div5_prod = 15'(task_word.setpoint) * 15'(DIV5_RECIP);
    always_comb
    begin
        if (div5_prod[14:10] == 5'd0)
            idx = 5'd0;
        else if (div5_prod[14:10] > 5'(TABLE_ENTRIES))
            idx = 5'(TABLE_ENTRIES - 1);
        else
            idx = div5_prod[14:10] - 5'd1;
    end

    // error / 20, truncated toward zero
    assign tbl    = level_table(s1_idx_reg);
    assign err    = $signed({1'b0, s1_avg_reg}) - $signed({1'b0, tbl});
    assign mag9   = err[8] ? 9'(-err) : 9'(err);
    assign q_prod = 20'(mag9[7:0]) * 20'(ERR_RECIP);
    assign q_mag  = q_prod[19:16];
    assign q      = err[8] ? -$signed({1'b0, q_mag}) : $signed({1'b0, q_mag});

    // integral clamp and duty
    assign active = (s2_setpoint_reg != 7'd0);
    assign lim    = $signed({2'b00, integral_limit});
    always_comb
    begin
        isum = $signed({integ_reg[15], integ_reg}) + $signed({{12{s2_q_reg[4]}}, s2_q_reg});
        if (isum > lim)
            isum = lim;
        else if (isum < INT_FLOOR)
            isum = INT_FLOOR;
        integ_next = isum[15:0];
        p = $signed({{9{s2_err_reg[8]}}, s2_err_reg, 1'b0}) +
            $signed({{2{integ_next[15]}}, integ_next, 1'b0});
        if (p < 19'sd0)
            duty = 8'd0;
        else if (p > 19'sd255)
            duty = 8'd255;
        else
            duty = p[7:0];
        if (!active || !s2_gate_reg)
            duty = 8'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            integ_reg    <= '0;
        end
        else if (adv)
        begin
            s1_valid_reg <= !task_empty;
            s2_valid_reg <= s1_valid_reg;
            if (s2_valid_reg && active)
                integ_reg <= integ_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_avg_reg      <= avg_prod[AVG_SHIFT +: 8];
            s1_idx_reg      <= idx;
            s1_setpoint_reg <= task_word.setpoint;
            s1_level_reg    <= task_word.battery_level;
            s1_gate_reg     <= task_word.drive_enable && !task_word.battery_low;
            s2_err_reg      <= err;
            s2_q_reg        <= q;
            s2_avg_reg      <= s1_avg_reg;
            s2_setpoint_reg <= s1_setpoint_reg;
            s2_level_reg    <= s1_level_reg;
            s2_gate_reg     <= s1_gate_reg;
        end
    end

    assign out_push               = s2_valid_reg && adv;
    assign out_word.duty          = duty;
    assign out_word.setpoint      = s2_setpoint_reg;
    assign out_word.battery_level = s2_level_reg;
    assign out_word.motor_average = s2_avg_reg;

endmodule

`default_nettype wire
